// ===== hdl/bth_pkg.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator package
// Shared payload types, status codes, datapath commands and status flags.
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int HEAP_WORDS_DEF  = 4096;
  localparam int CHUNK_BYTES_DEF = 4096;
  localparam int ADDR_W          = 14;
  localparam int STATUS_W        = 2;

  localparam logic                FUNC_FREE   = 1'b1;
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OOM  = 2'd2;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] request_bytes;
    logic [ADDR_W-1:0] payload_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
  } out_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_CLR, OP_INIT0, OP_INIT1, OP_INIT2, OP_LOAD, OP_WRD, OP_WCHK,
    OP_PICK, OP_GROW0, OP_GROW1, OP_GROW2, OP_FREE0, OP_FREE1,
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
    OP_SUMN, OP_SUMP, OP_SUMPN, OP_WHB, OP_WFB, OP_WFS, OP_WHP, OP_WFN,
    OP_P0, OP_P1, OP_PS0, OP_PS1, OP_PS2, OP_PS3, OP_PN0, OP_PN1, OP_PN2,
    OP_RESP_OK, OP_RESP_ZERO, OP_RESP_OOM, OP_RESP_FREE
  } dp_op_t;

  typedef struct packed {
    logic clr_last;
    logic zero_req;
    logic func;
    logic walk_end;
    logic h_stop;
    logic match;
    logic h_alloc;
    logic best_none;
    logic grow_fail;
    logic pa;
    logic na;
    logic split;
  } dp_status_t;

  // Byte address width: room for sums of addresses and sizes.
  function automatic int addr_width(input int heap_words);
    int w;
    w = $clog2(heap_words) + 4;
    return (w < 19) ? 19 : w;
  endfunction

endpackage

// ===== hdl/boundary_tag_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// Boundary-tag heap allocator
// Best-fit allocator over a word-addressed heap with header and footer tags.
//
//   Channel  Direction  Handshake             Payload
//   in_      request    in_valid / in_ready   bth_pkg::in_t
//   out_     result     out_valid / out_ready bth_pkg::out_t
//
// A non-zero allocation request walks every block, reading each header,
// then grows the heap if no free block fits, merges, places the block and
// presents the result; a free request walks until it reaches its block and,
// if that block is allocated, frees and merges it. After reset a clearing
// pass over all HEAP_WORDS words and the initial growth run before the first
// request is taken. A new request is taken while the previous result still
// waits in the output register.
module boundary_tag_heap_allocator #(
  parameter int HEAP_WORDS  = bth_pkg::HEAP_WORDS_DEF,
  parameter int CHUNK_BYTES = bth_pkg::CHUNK_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bth_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bth_pkg::out_t out_data
);

  bth_pkg::dp_op_t     op;
  bth_pkg::dp_status_t st;

  bth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .op        (op)
  );

  bth_dpath #(
    .HEAP_WORDS  (HEAP_WORDS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_data  (in_data),
    .st       (st),
    .out_data (out_data)
  );

endmodule

// ===== hdl/bth_mem.sv =====
// ----------------------------------------------------------------------------
// Heap word memory
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
module bth_mem #(
  parameter int DEPTH = bth_pkg::HEAP_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] idx,
  input  logic [31:0]              wdata,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    if (re) begin
      rdata <= mem[idx];
    end
  end

endmodule

// ===== hdl/bth_dpath.sv =====
// ----------------------------------------------------------------------------
// Heap allocator datapath
// Address and size registers, the break, the heap memory and the result
// register, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module bth_dpath #(
  parameter int HEAP_WORDS  = bth_pkg::HEAP_WORDS_DEF,
  parameter int CHUNK_BYTES = bth_pkg::CHUNK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bth_pkg::dp_op_t     op,
  input  bth_pkg::in_t        in_data,
  output bth_pkg::dp_status_t st,
  output bth_pkg::out_t       out_data
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int AW = bth_pkg::addr_width(HEAP_WORDS);
  localparam int CW = CHUNK_BYTES / 4;
  localparam logic [AW-1:0] HB = AW'(HEAP_WORDS * 4);
  localparam logic [AW-1:0] CB = AW'(CHUNK_BYTES);
  localparam logic [AW-1:0] CG = AW'((CW + (CW % 2)) * 4);

  logic                       func_r;
  logic [bth_pkg::ADDR_W-1:0] req_r, addr_r;
  logic [AW-1:0] asize_r, g_r, brk_r, bp_r, best_r, bsz_r, s_r, ps_r, ns_r;
  logic [AW-1:0] pbp_r, nbp_r, v_r;
  logic [31:0]   o_r;
  logic          pa_r, na_r, split_r, oob_r;
  logic [IW-1:0] clr_r;
  bth_pkg::out_t res_r;

  logic          mem_we, mem_re, in_range;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata, mem_q, rdata;
  logic [AW-1:0] rsz, osz, in_asize;
  logic [AW-1:0] req_ext;

  function automatic logic [AW-1:0] sz(input logic [31:0] w);
    return {w[AW-1:3], 3'b000};
  endfunction

  assign rdata    = oob_r ? 32'd0 : mem_q;
  assign rsz      = sz(rdata);
  assign osz      = sz(o_r);
  assign in_range = mem_addr[AW-1:2] < (AW-2)'(HEAP_WORDS);
  assign req_ext  = AW'(in_data.request_bytes);
  assign in_asize = (req_ext < AW'(8)) ? AW'(16) : ((req_ext + AW'(15)) & ~AW'(7));

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    case (op)
      bth_pkg::OP_CLR:   begin mem_we = 1'b1; mem_addr = AW'({clr_r, 2'b00}); end
      bth_pkg::OP_INIT0: begin mem_we = 1'b1; mem_addr = AW'(4); mem_wdata = 32'd9; end
      bth_pkg::OP_INIT1: begin mem_we = 1'b1; mem_addr = AW'(8); mem_wdata = 32'd9; end
      bth_pkg::OP_INIT2: begin mem_we = 1'b1; mem_addr = AW'(12); mem_wdata = 32'd1; end
      bth_pkg::OP_WRD:   begin mem_re = 1'b1; mem_addr = bp_r - AW'(4); end
      bth_pkg::OP_GROW0: begin
        mem_we = 1'b1; mem_addr = brk_r - AW'(4); mem_wdata = 32'(g_r);
      end
      bth_pkg::OP_GROW1: begin
        mem_we = 1'b1; mem_addr = bp_r + g_r - AW'(8); mem_wdata = 32'(g_r);
      end
      bth_pkg::OP_GROW2: begin
        mem_we = 1'b1; mem_addr = bp_r + g_r - AW'(4); mem_wdata = 32'd1;
      end
      bth_pkg::OP_FREE0: begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = 32'(s_r);
      end
      bth_pkg::OP_FREE1: begin
        mem_we = 1'b1; mem_addr = bp_r + s_r - AW'(8); mem_wdata = 32'(s_r);
      end
      bth_pkg::OP_M0:    begin mem_re = 1'b1; mem_addr = bp_r - AW'(8); end
      bth_pkg::OP_M1:    begin mem_re = 1'b1; mem_addr = bp_r - AW'(4); end
      bth_pkg::OP_M2:    begin mem_re = 1'b1; mem_addr = pbp_r - AW'(4); end
      bth_pkg::OP_M3:    begin mem_re = 1'b1; mem_addr = pbp_r + rsz - AW'(8); end
      bth_pkg::OP_M4:    begin mem_re = 1'b1; mem_addr = nbp_r - AW'(4); end
      bth_pkg::OP_WHB:   begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = 32'(v_r);
      end
      bth_pkg::OP_WFB:   begin
        mem_we = 1'b1; mem_addr = bp_r + v_r - AW'(8); mem_wdata = 32'(v_r);
      end
      bth_pkg::OP_WFS:   begin
        mem_we = 1'b1; mem_addr = bp_r + s_r - AW'(8); mem_wdata = 32'(v_r);
      end
      bth_pkg::OP_WHP:   begin
        mem_we = 1'b1; mem_addr = pbp_r - AW'(4); mem_wdata = 32'(v_r);
      end
      bth_pkg::OP_WFN:   begin
        mem_we = 1'b1; mem_addr = nbp_r + ns_r - AW'(8); mem_wdata = 32'(v_r);
      end
      bth_pkg::OP_P0:    begin mem_re = 1'b1; mem_addr = bp_r - AW'(4); end
      bth_pkg::OP_PS0:   begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = 32'(asize_r) | 32'd1;
      end
      bth_pkg::OP_PS1:   begin
        mem_we = 1'b1; mem_addr = bp_r + asize_r - AW'(8);
        mem_wdata = 32'(asize_r) | 32'd1;
      end
      bth_pkg::OP_PS2:   begin
        mem_we = 1'b1; mem_addr = bp_r + asize_r - AW'(4);
        mem_wdata = o_r - 32'(asize_r);
      end
      bth_pkg::OP_PS3:   begin
        mem_we = 1'b1; mem_addr = bp_r + osz - AW'(8);
        mem_wdata = o_r - 32'(asize_r);
      end
      bth_pkg::OP_PN0:   begin
        mem_we = 1'b1; mem_addr = bp_r - AW'(4); mem_wdata = o_r | 32'd1;
      end
      bth_pkg::OP_PN1:   begin mem_re = 1'b1; mem_addr = bp_r + osz - AW'(8); end
      bth_pkg::OP_PN2:   begin
        mem_we = 1'b1; mem_addr = bp_r + osz - AW'(8); mem_wdata = rdata | 32'd1;
      end
      default:  begin end
    endcase
  end

  bth_mem #(
    .DEPTH (HEAP_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we && in_range),
    .re    (mem_re && in_range),
    .idx   (mem_addr[IW+1:2]),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      oob_r <= 1'b0;
    end else begin
      if (op == bth_pkg::OP_CLR) begin
        clr_r <= clr_r + IW'(1);
      end
      if (mem_re) begin
        oob_r <= !in_range;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      bth_pkg::OP_INIT2: begin brk_r <= AW'(16); g_r <= CG; end
      bth_pkg::OP_LOAD: begin
        func_r  <= in_data.func;
        req_r   <= in_data.request_bytes;
        addr_r  <= in_data.payload_address;
        asize_r <= in_asize;
        g_r     <= (in_asize > CB) ? in_asize : CG;
        bp_r    <= AW'(16);
        best_r  <= '0;
        bsz_r   <= '0;
      end
      bth_pkg::OP_WCHK: begin
        s_r <= rsz;
        if (!(func_r && bp_r == AW'(addr_r))) begin
          bp_r <= bp_r + rsz;
        end
        if (!func_r && !rdata[0] && rsz >= asize_r && (best_r == '0 || bsz_r > rsz)) begin
          best_r <= bp_r;
          bsz_r  <= rsz;
        end
      end
      bth_pkg::OP_PICK:  bp_r <= best_r;
      bth_pkg::OP_GROW0: begin bp_r <= brk_r; brk_r <= brk_r + g_r; end
      bth_pkg::OP_M1:    pbp_r <= bp_r - rsz;
      bth_pkg::OP_M2:    begin s_r <= rsz; nbp_r <= bp_r + rsz; end
      bth_pkg::OP_M3:    ps_r <= rsz;
      bth_pkg::OP_M4:    pa_r <= rdata[0];
      bth_pkg::OP_M5:    begin na_r <= rdata[0]; ns_r <= rsz; end
      bth_pkg::OP_SUMN:  v_r <= s_r + ns_r;
      bth_pkg::OP_SUMP:  v_r <= s_r + ps_r;
      bth_pkg::OP_SUMPN: v_r <= v_r + ns_r;
      bth_pkg::OP_WHP:   bp_r <= pbp_r;
      bth_pkg::OP_P1: begin
        o_r     <= rdata;
        split_r <= (32'(asize_r) + 32'd16) <= rdata;
      end
      bth_pkg::OP_RESP_OK:   res_r <= '{result_address: bp_r[bth_pkg::ADDR_W-1:0],
                                        status: bth_pkg::STATUS_OK};
      bth_pkg::OP_RESP_ZERO: res_r <= '{result_address: '0, status: bth_pkg::STATUS_ZERO};
      bth_pkg::OP_RESP_OOM:  res_r <= '{result_address: '0, status: bth_pkg::STATUS_OOM};
      bth_pkg::OP_RESP_FREE: res_r <= '{result_address: '0, status: bth_pkg::STATUS_OK};
      default: begin end
    endcase
  end

  assign st.clr_last  = clr_r == IW'(HEAP_WORDS - 1);
  assign st.zero_req  = req_r == '0;
  assign st.func      = func_r;
  assign st.walk_end  = bp_r > brk_r;
  assign st.h_stop    = (rdata == 32'd1) || (rsz == '0);
  assign st.match     = bp_r == AW'(addr_r);
  assign st.h_alloc   = rdata[0];
  assign st.best_none = best_r == '0;
  assign st.grow_fail = (brk_r > HB) || (g_r > HB - brk_r);
  assign st.pa        = pa_r;
  assign st.na        = na_r;
  assign st.split     = split_r;
  assign out_data     = res_r;

endmodule

// ===== hdl/bth_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heap allocator controller
// Sequences clearing, initialisation, the block walk, growth, merging and
// placement, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module bth_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bth_pkg::dp_status_t st,
  output bth_pkg::dp_op_t     op
);

  localparam int NS = 39;

  typedef enum logic [NS-1:0] {
    S_CLR   = NS'(1) << 0,  S_INIT0 = NS'(1) << 1,  S_INIT1 = NS'(1) << 2,
    S_INIT2 = NS'(1) << 3,  S_IDLE  = NS'(1) << 4,  S_WRD   = NS'(1) << 5,
    S_WCHK  = NS'(1) << 6,  S_WEND  = NS'(1) << 7,  S_GCHK  = NS'(1) << 8,
    S_GROW0 = NS'(1) << 9,  S_GROW1 = NS'(1) << 10, S_GROW2 = NS'(1) << 11,
    S_FREE0 = NS'(1) << 12, S_FREE1 = NS'(1) << 13, S_M0    = NS'(1) << 14,
    S_M1    = NS'(1) << 15, S_M2    = NS'(1) << 16, S_M3    = NS'(1) << 17,
    S_M4    = NS'(1) << 18, S_M5    = NS'(1) << 19, S_MDEC  = NS'(1) << 20,
    S_SUMN  = NS'(1) << 21, S_SUMP  = NS'(1) << 22, S_SUMPN = NS'(1) << 23,
    S_WHB   = NS'(1) << 24, S_WFB   = NS'(1) << 25, S_WFS   = NS'(1) << 26,
    S_WHP   = NS'(1) << 27, S_WFN   = NS'(1) << 28, S_P0    = NS'(1) << 29,
    S_P1    = NS'(1) << 30, S_PS0   = NS'(1) << 31, S_PS1   = NS'(1) << 32,
    S_PS2   = NS'(1) << 33, S_PS3   = NS'(1) << 34, S_PN0   = NS'(1) << 35,
    S_PN1   = NS'(1) << 36, S_PN2   = NS'(1) << 37, S_DONE  = NS'(1) << 38
  } state_t;

  state_t          state_r, state_nxt, after_st;
  logic            init_r, init_nxt, out_valid_r, out_valid_nxt;
  bth_pkg::dp_op_t resp_r, resp_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign after_st  = init_r ? S_IDLE : (st.func ? S_DONE : S_P0);

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    resp_nxt      = resp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = bth_pkg::OP_NOP;
    unique case (state_r)
      S_CLR: begin
        op = bth_pkg::OP_CLR;
        if (st.clr_last) begin
          state_nxt = S_INIT0;
        end
      end
      S_INIT0: begin op = bth_pkg::OP_INIT0; state_nxt = S_INIT1; end
      S_INIT1: begin op = bth_pkg::OP_INIT1; state_nxt = S_INIT2; end
      S_INIT2: begin op = bth_pkg::OP_INIT2; state_nxt = S_GCHK; end
      S_IDLE: begin
        if (in_valid) begin
          op        = bth_pkg::OP_LOAD;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        op = bth_pkg::OP_WRD;
        if (!st.func && st.zero_req) begin
          resp_nxt  = bth_pkg::OP_RESP_ZERO;
          state_nxt = S_DONE;
        end else if (st.walk_end) begin
          resp_nxt  = bth_pkg::OP_RESP_FREE;
          state_nxt = st.func ? S_DONE : S_WEND;
        end else begin
          state_nxt = S_WCHK;
        end
      end
      S_WCHK: begin
        op = bth_pkg::OP_WCHK;
        if (st.h_stop) begin
          resp_nxt  = bth_pkg::OP_RESP_FREE;
          state_nxt = st.func ? S_DONE : S_WEND;
        end else if (st.func && st.match) begin
          resp_nxt  = bth_pkg::OP_RESP_FREE;
          state_nxt = st.h_alloc ? S_FREE0 : S_DONE;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_WEND: begin
        op        = bth_pkg::OP_PICK;
        state_nxt = st.best_none ? S_GCHK : S_P0;
      end
      S_GCHK: begin
        if (st.grow_fail) begin
          resp_nxt  = bth_pkg::OP_RESP_OOM;
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_DONE;
        end else begin
          state_nxt = S_GROW0;
        end
      end
      S_GROW0: begin op = bth_pkg::OP_GROW0; state_nxt = S_GROW1; end
      S_GROW1: begin op = bth_pkg::OP_GROW1; state_nxt = S_GROW2; end
      S_GROW2: begin op = bth_pkg::OP_GROW2; state_nxt = S_M0; end
      S_FREE0: begin op = bth_pkg::OP_FREE0; state_nxt = S_FREE1; end
      S_FREE1: begin op = bth_pkg::OP_FREE1; state_nxt = S_M0; end
      S_M0: begin op = bth_pkg::OP_M0; state_nxt = S_M1; end
      S_M1: begin op = bth_pkg::OP_M1; state_nxt = S_M2; end
      S_M2: begin op = bth_pkg::OP_M2; state_nxt = S_M3; end
      S_M3: begin op = bth_pkg::OP_M3; state_nxt = S_M4; end
      S_M4: begin op = bth_pkg::OP_M4; state_nxt = S_M5; end
      S_M5: begin op = bth_pkg::OP_M5; state_nxt = S_MDEC; end
      S_MDEC: begin
        if (st.pa && st.na) begin
          state_nxt = after_st;
          init_nxt  = 1'b0;
        end else begin
          state_nxt = st.pa ? S_SUMN : S_SUMP;
        end
      end
      S_SUMN: begin op = bth_pkg::OP_SUMN; state_nxt = S_WHB; end
      S_WHB:  begin op = bth_pkg::OP_WHB; state_nxt = S_WFB; end
      S_WFB: begin
        op        = bth_pkg::OP_WFB;
        state_nxt = after_st;
        init_nxt  = 1'b0;
      end
      S_SUMP: begin
        op        = bth_pkg::OP_SUMP;
        state_nxt = st.na ? S_WFS : S_SUMPN;
      end
      S_WFS:   begin op = bth_pkg::OP_WFS; state_nxt = S_WHP; end
      S_SUMPN: begin op = bth_pkg::OP_SUMPN; state_nxt = S_WHP; end
      S_WHP: begin
        op = bth_pkg::OP_WHP;
        if (st.na) begin
          state_nxt = after_st;
          init_nxt  = 1'b0;
        end else begin
          state_nxt = S_WFN;
        end
      end
      S_WFN: begin
        op        = bth_pkg::OP_WFN;
        state_nxt = after_st;
        init_nxt  = 1'b0;
      end
      S_P0: begin op = bth_pkg::OP_P0; state_nxt = S_P1; end
      S_P1: begin
        op        = bth_pkg::OP_P1;
        resp_nxt  = bth_pkg::OP_RESP_OK;
        state_nxt = S_PS0;
      end
      S_PS0: begin
        op        = st.split ? bth_pkg::OP_PS0 : bth_pkg::OP_PN0;
        state_nxt = st.split ? S_PS1 : S_PN1;
      end
      S_PS1: begin op = bth_pkg::OP_PS1; state_nxt = S_PS2; end
      S_PS2: begin op = bth_pkg::OP_PS2; state_nxt = S_PS3; end
      S_PS3: begin op = bth_pkg::OP_PS3; state_nxt = S_DONE; end
      S_PN0: begin state_nxt = S_PN1; end
      S_PN1: begin op = bth_pkg::OP_PN1; state_nxt = S_PN2; end
      S_PN2: begin op = bth_pkg::OP_PN2; state_nxt = S_DONE; end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          op            = resp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      resp_r      <= bth_pkg::OP_RESP_FREE;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      resp_r      <= resp_nxt;
    end
  end

  a_accept_walks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_WRD)
    else $error("accepted request did not start the walk");
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !in_ready)
    else $error("request accepted during initialisation");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the completion state");
  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("completion did not present a result");

endmodule
